// File: rtl/pixel_to_packed_row_bytes_top_macros.svh
// Assertion helpers shared by the packer blocks.
// Both expect a clock named clk and an active-high reset named rst in scope.
`ifndef PIXEL_TO_PACKED_ROW_BYTES_TOP_MACROS_SVH
`define PIXEL_TO_PACKED_ROW_BYTES_TOP_MACROS_SVH

// same-cycle implication
`define PPRB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PPRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pprb_pkg.sv
`timescale 1ns / 1ps
package pprb_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // register indexes
  localparam cfg_idx_t REG_DEPTH_MODE = 2'd0;
  localparam cfg_idx_t REG_ROW_WIDTH  = 2'd1;

  // depth codes
  localparam logic [2:0] DM_1BPP  = 3'd0;
  localparam logic [2:0] DM_4BPP  = 3'd1;
  localparam logic [2:0] DM_8BPP  = 3'd2;
  localparam logic [2:0] DM_16BPP = 3'd3;
  localparam logic [2:0] DM_24BPP = 3'd4;
  localparam logic [2:0] DM_32BPP = 3'd5;

  localparam logic [2:0]  DEPTH_RESET     = DM_8BPP;
  localparam logic [12:0] ROW_WIDTH_RESET = 13'd640;

  // bytes produced by one pixel, handed from packer to serializer
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      count;   // 0..4
    logic            rend;
  } grp_t;

endpackage

// File: rtl/pprb_if.sv
`timescale 1ns / 1ps
interface pprb_pix_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface pprb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       row_end;

  modport source (output valid, output out_byte, output last_of_run, output row_end,
                  input ready);
  modport sink   (input valid, input out_byte, input last_of_run, input row_end,
                  output ready);
endinterface

// File: rtl/pixel_to_packed_row_bytes_top.sv
`timescale 1ns / 1ps
// Packs a stream of pixels into the bytes of a device bitmap row.
// pixels: one 32-bit pixel per beat, in row order (valid/ready).
// bytes:  one packed byte per beat with last_of_run (last byte from a pixel)
//         and row_end (last byte of the row's final pixel).
// wr_en/wr_index/wr_data: register 0 is depth_mode, 1 is row_width; a write to
//   either restarts the row. Write only while the block is idle.
// The first byte from a pixel is valid the cycle after that pixel's beat.
//   At 1, 4 and 8 bpp a pixel can be taken every cycle unless output stalls;
//   at 16, 24 and 32 bpp its 2, 3 or 4 bytes go out in turn on the single
//   byte output port. A 1 or 4 bpp pixel leaving its byte open yields no beat.
// A new pixel is taken in the same cycle the last byte of the previous one
//   is taken, so the stream runs without bubbles.
// If the receiver stalls, the current byte holds and no pixel is taken while
//   any byte of the held group is waiting, so pixels back up behind it.
// Reset (rst, synchronous): depth_mode 8 bpp, row_width 640, row restarts,
//   no byte pending.
module pixel_to_packed_row_bytes_top #(
  parameter int MAX_ROW_WIDTH = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  pprb_pkg::cfg_idx_t  wr_index,
  input  pprb_pkg::cfg_data_t wr_data,
  pprb_pix_if.sink            pixels,
  pprb_byte_if.source         bytes
);
  import pprb_pkg::*;

  grp_t grp;
  logic load_ready;
  logic take;

  assign pixels.ready = load_ready;
  assign take         = pixels.valid && load_ready;

  pprb_pack #(
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
  ) u_pack (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .take     (take),
    .pixel    (pixels.pixel),
    .grp      (grp)
  );

  pprb_ser u_ser (
    .clk        (clk),
    .rst        (rst),
    .grp        (grp),
    .load       (take),
    .load_ready (load_ready),
    .bytes_o    (bytes)
  );

endmodule

// File: rtl/pprb_pack.sv
`timescale 1ns / 1ps
`include "pixel_to_packed_row_bytes_top_macros.svh"
module pprb_pack #(
  parameter int MAX_ROW_WIDTH = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  pprb_pkg::cfg_idx_t  wr_index,
  input  pprb_pkg::cfg_data_t wr_data,
  input  logic                take,
  input  logic [31:0]         pixel,
  output pprb_pkg::grp_t      grp
);
  import pprb_pkg::*;

  localparam int CW = $clog2(MAX_ROW_WIDTH);
  localparam int WW = (CW + 1 > CFG_DATA_W) ? CW + 1 : CFG_DATA_W;
  localparam logic [WW-1:0] MAXW = WW'(MAX_ROW_WIDTH);

  logic [2:0]    depth_mode;
  logic [12:0]   row_width;
  logic [7:0]    acc;
  logic [7:0]    acc_next;
  logic [CW-1:0] col;
  logic [CW-1:0] col_next;

  logic [WW-1:0] rw_ext;
  logic [WW-1:0] eff_w;
  logic [CW-1:0] wm1;
  logic          rend;
  logic [CW-1:0] c;
  logic [7:0]    bit_acc;
  logic [7:0]    emit;

  assign rw_ext = WW'(row_width);

  always_comb begin
    if (rw_ext == '0) begin
      eff_w = WW'(1);
    end else if (rw_ext > MAXW) begin
      eff_w = MAXW;
    end else begin
      eff_w = rw_ext;
    end
  end

  assign wm1  = CW'(eff_w - WW'(1));
  assign rend = (col >= wm1);
  assign c    = rend ? wm1 : col;

  // 1 bpp: start a fresh byte at each multiple of eight columns
  assign bit_acc = ((c[2:0] == 3'd0) ? 8'h00 : acc) | ({7'd0, pixel[0]} << (3'd7 - c[2:0]));

  always_comb begin
    acc_next  = acc;
    emit      = 8'h00;
    grp.bytes = {24'd0, 8'h00};
    grp.count = 3'd0;
    grp.rend  = rend;
    case (depth_mode)
      DM_1BPP: begin
        acc_next = bit_acc;
        if (c[2:0] == 3'd7 || rend) begin
          emit      = bit_acc;
          grp.count = 3'd1;
          acc_next  = 8'h00;
        end
        grp.bytes = {24'd0, emit};
      end
      DM_4BPP: begin
        if (!c[0]) begin
          acc_next = {pixel[3:0], 4'h0};
          if (rend) begin
            emit      = {pixel[3:0], 4'h0};
            grp.count = 3'd1;
          end
        end else begin
          emit      = {acc[7:4], pixel[3:0]};
          grp.count = 3'd1;
          acc_next  = 8'h00;
        end
        grp.bytes = {24'd0, emit};
      end
      DM_8BPP: begin
        grp.bytes = pixel;
        grp.count = 3'd1;
      end
      DM_16BPP: begin
        grp.bytes = pixel;
        grp.count = 3'd2;
      end
      DM_24BPP: begin
        grp.bytes = pixel;
        grp.count = 3'd3;
      end
      DM_32BPP: begin
        grp.bytes = pixel;
        grp.count = 3'd4;
      end
      default: begin
        acc_next = 8'h00;
      end
    endcase
    if (rend) begin
      acc_next = 8'h00;
    end
  end

  assign col_next = rend ? '0 : c + CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_mode <= DEPTH_RESET;
      row_width  <= ROW_WIDTH_RESET;
      acc        <= 8'h00;
      col        <= '0;
    end else if (wr_en) begin
      if (wr_index == REG_DEPTH_MODE) begin
        depth_mode <= wr_data[2:0];
        acc        <= 8'h00;
        col        <= '0;
      end else if (wr_index == REG_ROW_WIDTH) begin
        row_width <= wr_data;
        acc       <= 8'h00;
        col       <= '0;
      end
    end else if (take) begin
      acc <= acc_next;
      col <= col_next;
    end
  end

  `PPRB_ASSERT_NEXT(a_col_in_row, 1'b1, col <= wm1, "column count ran past the row width")

endmodule

// File: rtl/pprb_ser.sv
`timescale 1ns / 1ps
`include "pixel_to_packed_row_bytes_top_macros.svh"
module pprb_ser (
  input  logic           clk,
  input  logic           rst,
  input  pprb_pkg::grp_t grp,
  input  logic           load,
  output logic           load_ready,
  pprb_byte_if.source    bytes_o
);
  import pprb_pkg::*;

  logic [3:0][7:0] bytes;
  logic [1:0]      idx;
  logic [1:0]      lastidx;
  logic            rend;
  logic            busy;
  logic            last;

  assign last       = (idx == lastidx);
  assign load_ready = !busy || (bytes_o.ready && last);

  assign bytes_o.valid       = busy;
  assign bytes_o.out_byte    = bytes[idx];
  assign bytes_o.last_of_run = last;
  assign bytes_o.row_end     = last && rend;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (load) begin
      busy <= (grp.count != 3'd0);
      idx  <= 2'd0;
    end else if (busy && bytes_o.ready) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes   <= grp.bytes;
      lastidx <= 2'(grp.count - 3'd1);
      rend    <= grp.rend;
    end
  end

  `PPRB_ASSERT_NEXT(a_hold_on_stall, busy && !bytes_o.ready, busy && $stable(idx), "stalled beat moved")
  `PPRB_ASSERT_NOW(a_idx_bound, busy, idx <= lastidx, "byte index beyond the pixel's bytes")
  `PPRB_ASSERT_NEXT(a_drain, busy && bytes_o.ready && last && !load, !busy, "group not retired")

endmodule
